@@ rtl/swls_pkg.sv @@
package swls_pkg;

    // Field widths of the stream items
    localparam int LVL_W   = 16;
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int DIST_W  = 25;
    localparam int FILL_W  = 7;

    // Squared distance and root widths
    localparam int SQ_W    = 2 * DIFF_W + 2;
    localparam int DIST_RW = SQ_W / 2;
    localparam int DEV_RW  = DIST_W;

    // Packed stream widths
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 176;

    // One classified item as it travels from front to back
    typedef struct packed {
        logic signed [LVL_W-1:0] level;
        logic [DIST_W-1:0]       distance;
        logic                    pos_valid;
    } t_entry;

    // Push side of the item queue
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_handoff;

endpackage

@@ rtl/swls_div.sv @@
module swls_div #(
    parameter int DW = 57,
    parameter int VW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quot;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    // Restoring step: one quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_quot[DW-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= CW'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quot <= {r_quot[DW-2:0], ge};
                r_rem  <= ge ? diff[VW-1:0] : trial[VW-1:0];
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

@@ rtl/swls_isqrt.sv @@
module swls_isqrt #(
    parameter int RW = 25
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2*RW-1:0] i_radicand,
    output logic            o_done,
    output logic [RW-1:0]   o_root
);

    localparam int CW = $clog2(RW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [2*RW-1:0] r_rad;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [RW+3:0]   cur;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            ge;

    // Digit-by-digit root: two radicand bits in, one root bit out
    always_comb begin
        cur   = {r_rem, r_rad[2*RW-1 -: 2]};
        trial = {2'b00, r_root, 2'b01};
        diff  = cur - trial;
        ge    = (cur >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CW'(RW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[2*RW-3:0], 2'b00};
                r_rem  <= ge ? diff[RW+1:0] : cur[RW+1:0];
                r_root <= {r_root[RW-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ rtl/swls_front.sv @@
module swls_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_tvalid,
    output logic                                o_tready,
    input  logic [swls_pkg::IN_TDATA_W-1:0]     i_tdata,
    input  logic                                i_tuser,
    output swls_pkg::t_handoff                  o_push,
    input  logic                                i_full
);

    typedef enum logic [1:0] {F_IDLE, F_SQ, F_ROOT, F_PUSH} t_fstate;

    t_fstate                                  r_state;
    logic signed [swls_pkg::LVL_W-1:0]        r_level;
    logic                                     r_pv;
    logic signed [swls_pkg::DIFF_W-1:0]       r_dx;
    logic signed [swls_pkg::DIFF_W-1:0]       r_dy;
    logic signed [swls_pkg::DIFF_W-1:0]       r_dz;
    logic [1:0]                               r_k;
    logic [2*swls_pkg::DIFF_W-1:0]            r_prod;
    logic                                     r_prod_v;
    logic [swls_pkg::SQ_W-1:0]                r_acc;
    logic                                     r_launch;
    logic [swls_pkg::DIST_W-1:0]              r_dist;

    logic signed [swls_pkg::DIFF_W-1:0]       sel_d;
    logic signed [2*swls_pkg::DIFF_W-1:0]     sq;
    logic                                     root_start;
    logic                                     root_done;
    logic [swls_pkg::DIST_RW-1:0]             root;
    logic signed [swls_pkg::DIFF_W-1:0]       n_dx;
    logic signed [swls_pkg::DIFF_W-1:0]       n_dy;
    logic signed [swls_pkg::DIFF_W-1:0]       n_dz;

    // Coordinate differences, sign extended by one bit
    always_comb begin
        n_dx = $signed({i_tdata[39], i_tdata[39:16]})
             - $signed({i_tdata[111], i_tdata[111:88]});
        n_dy = $signed({i_tdata[63], i_tdata[63:40]})
             - $signed({i_tdata[135], i_tdata[135:112]});
        n_dz = $signed({i_tdata[87], i_tdata[87:64]})
             - $signed({i_tdata[159], i_tdata[159:136]});
    end

    // One square per cycle through a shared multiplier
    always_comb begin
        case (r_k)
            2'd0:    sel_d = r_dx;
            2'd1:    sel_d = r_dy;
            default: sel_d = r_dz;
        endcase
        sq = sel_d * sel_d;
    end

    assign root_start = (r_state == F_ROOT) && !r_launch;
    assign o_tready   = (r_state == F_IDLE);

    swls_isqrt #(.RW(swls_pkg::DIST_RW)) u_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (r_acc),
        .o_done     (root_done),
        .o_root     (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_launch <= 1'b0;
            r_prod_v <= 1'b0;
            r_k      <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_tvalid) begin
                        r_level  <= $signed(i_tdata[15:0]);
                        r_pv     <= i_tuser;
                        r_dx     <= n_dx;
                        r_dy     <= n_dy;
                        r_dz     <= n_dz;
                        r_k      <= '0;
                        r_prod_v <= 1'b0;
                        r_acc    <= '0;
                        r_state  <= i_tuser ? F_SQ : F_PUSH;
                    end
                end
                F_SQ: begin
                    r_prod   <= $unsigned(sq);
                    r_prod_v <= (r_k != 2'd3);
                    if (r_prod_v) begin
                        r_acc <= r_acc + swls_pkg::SQ_W'(r_prod);
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        r_state <= F_ROOT;
                    end
                end
                F_ROOT: begin
                    if (!r_launch) begin
                        r_launch <= 1'b1;
                    end else if (root_done) begin
                        r_launch <= 1'b0;
                        r_dist   <= root[swls_pkg::DIST_W-1:0];
                        r_state  <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_comb begin
        o_push.valid              = (r_state == F_PUSH);
        o_push.entry.level        = r_level;
        o_push.entry.distance     = r_dist;
        o_push.entry.pos_valid    = r_pv;
    end

endmodule

@@ rtl/swls_fifo.sv @@
module swls_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swls_pkg::t_handoff i_push,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output swls_pkg::t_entry   o_head
);

    swls_pkg::t_entry r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             wr;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];
    assign wr      = i_push.valid && !o_full;

    // Two-entry queue between item front and statistics back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_mem[r_wp] <= i_push.entry;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, i_pop};
        end
    end

endmodule

@@ rtl/swls_back.sv @@
module swls_back #(
    parameter int WINDOW = 100
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  swls_pkg::t_entry                    i_head,
    output logic                                o_pop,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    output logic [swls_pkg::OUT_TDATA_W-1:0]    o_tdata,
    output logic                                o_tuser
);

    localparam int LW     = swls_pkg::LVL_W;
    localparam int DWD    = swls_pkg::DIST_W;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int LSUM_W = LW + CNT_W;
    localparam int DSUM_W = DWD + CNT_W;
    localparam int LQ_W   = 2 * LW + CNT_W;
    localparam int DQ_W   = 2 * DWD + CNT_W;
    localparam int DIV_W  = DQ_W;
    localparam int P_W    = 2 * CNT_W;
    localparam int VAR_W  = 2 * swls_pkg::DEV_RW;

    typedef enum logic [3:0] {
        B_IDLE, B_SCAN1, B_DIV_LM, B_DIV_DM, B_SCAN2, B_DIV_LQ,
        B_DIV_DQ, B_FIX1, B_FIX2, B_SQRT, B_OUT
    } t_bstate;

    t_bstate                 r_state;

    // Window stores
    logic signed [LW-1:0]    r_lvl_mem [WINDOW];
    logic [DWD-1:0]          r_dst_mem [WINDOW];
    logic signed [LW-1:0]    r_lvl_rd;
    logic [DWD-1:0]          r_dst_rd;

    logic [CNT_W-1:0]        r_held;
    logic [IDX_W-1:0]        r_oldest;
    logic [CNT_W-1:0]        r_addr;
    logic                    r_rd_v;
    logic                    r_sq_v;
    logic [2*LW-1:0]         r_lsq;
    logic [2*DWD-1:0]        r_dsq;

    // Accumulators
    logic signed [LW-1:0]    r_lmin;
    logic signed [LW-1:0]    r_lmax;
    logic signed [LSUM_W-1:0] r_lsum;
    logic [DWD-1:0]          r_dmin;
    logic [DWD-1:0]          r_dmax;
    logic [DSUM_W-1:0]       r_dsum;
    logic [LQ_W-1:0]         r_lq;
    logic [DQ_W-1:0]         r_dq;

    // Held statistics
    logic signed [LW-1:0]    r_st_lmin;
    logic signed [LW-1:0]    r_st_lmax;
    logic signed [LW-1:0]    r_st_lmean;
    logic [LW-1:0]           r_st_ldev;
    logic [DWD-1:0]          r_st_dmin;
    logic [DWD-1:0]          r_st_dmax;
    logic [DWD-1:0]          r_st_dmean;
    logic [DWD-1:0]          r_st_ddev;

    logic [CNT_W-1:0]        r_lrem;
    logic [CNT_W-1:0]        r_drem;
    logic [DIV_W-1:0]        r_q1;
    logic [CNT_W-1:0]        r_qrem;
    logic [P_W-1:0]          r_pa;
    logic [P_W-1:0]          r_pr;
    logic [P_W-1:0]          r_pd;
    logic [VAR_W-1:0]        r_var;
    logic                    r_dev_dist;
    logic                    r_launch;

    logic                    r_out_v;
    logic [swls_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic                    r_out_user;

    // Combinational helpers
    logic                    store;
    logic                    full;
    logic [IDX_W-1:0]        wr_slot;
    logic [CNT_W-1:0]        n_held;
    logic                    rd_en;
    logic                    scanning;
    logic                    div_state;
    logic                    div_start;
    logic [DIV_W-1:0]        div_dividend;
    logic [CNT_W-1:0]        div_divisor;
    logic                    div_done;
    logic [DIV_W-1:0]        div_quot;
    logic [CNT_W-1:0]        div_rem;
    logic [LSUM_W-1:0]       lsum_abs;
    logic signed [LW:0]      la;
    logic signed [DWD:0]     db;
    logic signed [2*LW+1:0]  la_sq;
    logic signed [2*DWD+1:0] db_sq;
    logic signed [P_W:0]     t_fix;
    logic [1:0]              dec;
    logic [DIV_W-1:0]        var_full;
    logic [CNT_W-1:0]        mrem;
    logic                    sq_start;
    logic                    sq_done;
    logic [swls_pkg::DEV_RW-1:0] sq_root;
    logic                    out_load;

    // Slot choice: append while filling, overwrite the oldest once full
    always_comb begin
        store   = (r_state == B_IDLE) && !i_empty && i_head.pos_valid;
        full    = (r_held == CNT_W'(WINDOW));
        wr_slot = full ? r_oldest : r_held[IDX_W-1:0];
        n_held  = full ? r_held : r_held + 1'b1;
    end

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign scanning = (r_state == B_SCAN1) || (r_state == B_SCAN2);
    assign rd_en    = scanning && (r_addr < r_held);

    // Window memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_lvl_mem[wr_slot] <= i_head.level;
            r_dst_mem[wr_slot] <= i_head.distance;
        end
        if (rd_en) begin
            r_lvl_rd <= r_lvl_mem[r_addr[IDX_W-1:0]];
            r_dst_rd <= r_dst_mem[r_addr[IDX_W-1:0]];
        end
    end

    // Divider operand selection
    always_comb begin
        lsum_abs     = r_lsum[LSUM_W-1] ? LSUM_W'(-r_lsum) : LSUM_W'(r_lsum);
        div_state    = (r_state == B_DIV_LM) || (r_state == B_DIV_DM) ||
                       (r_state == B_DIV_LQ) || (r_state == B_DIV_DQ);
        div_start    = div_state && !r_launch;
        div_divisor  = r_held - 1'b1;
        div_dividend = DIV_W'(r_dq);
        case (r_state)
            B_DIV_LM: begin
                div_dividend = DIV_W'(lsum_abs);
                div_divisor  = r_held;
            end
            B_DIV_DM: begin
                div_dividend = DIV_W'(r_dsum);
                div_divisor  = r_held;
            end
            B_DIV_LQ: div_dividend = DIV_W'(r_lq);
            default:  div_dividend = DIV_W'(r_dq);
        endcase
    end

    swls_div #(.DW(DIV_W), .VW(CNT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign sq_start = (r_state == B_SQRT) && !r_launch;

    swls_isqrt #(.RW(swls_pkg::DEV_RW)) u_dev_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_var),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // Deviations from the truncated means, and the variance correction
    always_comb begin
        la    = $signed({r_lvl_rd[LW-1], r_lvl_rd}) - $signed({r_st_lmean[LW-1], r_st_lmean});
        db    = $signed({1'b0, r_dst_rd}) - $signed({1'b0, r_st_dmean});
        la_sq = la * la;
        db_sq = db * db;
        mrem  = r_dev_dist ? r_drem : r_lrem;
        t_fix = $signed({1'b0, r_pa}) - $signed({1'b0, r_pr});
        if (!t_fix[P_W]) begin
            dec = 2'd0;
        end else if ((-t_fix) <= $signed({1'b0, r_pd})) begin
            dec = 2'd1;
        end else begin
            dec = 2'd2;
        end
        var_full = (r_q1 < DIV_W'(dec)) ? '0 : r_q1 - DIV_W'(dec);
        out_load = (r_state == B_OUT) && (!r_out_v || i_tready);
    end

    // Sequencer: store, two window scans, divides, roots, result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_held     <= '0;
            r_oldest   <= '0;
            r_addr     <= '0;
            r_rd_v     <= 1'b0;
            r_sq_v     <= 1'b0;
            r_launch   <= 1'b0;
            r_dev_dist <= 1'b0;
            r_out_v    <= 1'b0;
            r_st_lmin  <= '0;
            r_st_lmax  <= '0;
            r_st_lmean <= '0;
            r_st_ldev  <= '0;
            r_st_dmin  <= '0;
            r_st_dmax  <= '0;
            r_st_dmean <= '0;
            r_st_ddev  <= '0;
        end else begin
            r_rd_v <= rd_en;
            if (rd_en) begin
                r_addr <= r_addr + 1'b1;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_tready) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                B_IDLE: begin
                    r_addr <= '0;
                    r_lmin <= {1'b0, {(LW-1){1'b1}}};
                    r_lmax <= {1'b1, {(LW-1){1'b0}}};
                    r_lsum <= '0;
                    r_dmin <= '1;
                    r_dmax <= '0;
                    r_dsum <= '0;
                    r_lq   <= '0;
                    r_dq   <= '0;
                    r_sq_v <= 1'b0;
                    if (!i_empty) begin
                        if (i_head.pos_valid) begin
                            r_held <= n_held;
                            if (full) begin
                                r_oldest <= (r_oldest == IDX_W'(WINDOW - 1)) ?
                                            '0 : r_oldest + 1'b1;
                            end
                            r_state <= (n_held >= CNT_W'(2)) ? B_SCAN1 : B_OUT;
                        end else begin
                            r_state <= B_OUT;
                        end
                    end
                end
                B_SCAN1: begin
                    if (r_rd_v) begin
                        if (r_lvl_rd < r_lmin) r_lmin <= r_lvl_rd;
                        if (r_lvl_rd > r_lmax) r_lmax <= r_lvl_rd;
                        if (r_dst_rd < r_dmin) r_dmin <= r_dst_rd;
                        if (r_dst_rd > r_dmax) r_dmax <= r_dst_rd;
                        r_lsum <= r_lsum + $signed({{CNT_W{r_lvl_rd[LW-1]}}, r_lvl_rd});
                        r_dsum <= r_dsum + DSUM_W'(r_dst_rd);
                    end
                    if (!rd_en && !r_rd_v) begin
                        r_st_lmin <= r_lmin;
                        r_st_lmax <= r_lmax;
                        r_st_dmin <= r_dmin;
                        r_st_dmax <= r_dmax;
                        r_addr    <= '0;
                        r_state   <= B_DIV_LM;
                    end
                end
                B_DIV_LM: begin
                    if (!r_launch) begin
                        r_launch <= 1'b1;
                    end else if (div_done) begin
                        r_launch   <= 1'b0;
                        r_st_lmean <= r_lsum[LSUM_W-1] ? -$signed(div_quot[LW-1:0])
                                                       : $signed(div_quot[LW-1:0]);
                        r_lrem     <= div_rem;
                        r_state    <= B_DIV_DM;
                    end
                end
                B_DIV_DM: begin
                    if (!r_launch) begin
                        r_launch <= 1'b1;
                    end else if (div_done) begin
                        r_launch   <= 1'b0;
                        r_st_dmean <= div_quot[DWD-1:0];
                        r_drem     <= div_rem;
                        r_state    <= B_SCAN2;
                    end
                end
                B_SCAN2: begin
                    r_lsq  <= la_sq[2*LW-1:0];
                    r_dsq  <= db_sq[2*DWD-1:0];
                    r_sq_v <= r_rd_v;
                    if (r_sq_v) begin
                        r_lq <= r_lq + LQ_W'(r_lsq);
                        r_dq <= r_dq + DQ_W'(r_dsq);
                    end
                    if (!rd_en && !r_rd_v && !r_sq_v) begin
                        r_state <= B_DIV_LQ;
                    end
                end
                B_DIV_LQ, B_DIV_DQ: begin
                    if (!r_launch) begin
                        r_launch <= 1'b1;
                    end else if (div_done) begin
                        r_launch   <= 1'b0;
                        r_q1       <= div_quot;
                        r_qrem     <= div_rem;
                        r_dev_dist <= (r_state == B_DIV_DQ);
                        r_state    <= B_FIX1;
                    end
                end
                B_FIX1: begin
                    r_pa    <= P_W'(r_held) * P_W'(r_qrem);
                    r_pr    <= P_W'(mrem) * P_W'(mrem);
                    r_pd    <= P_W'(r_held) * P_W'(r_held - 1'b1);
                    r_state <= B_FIX2;
                end
                B_FIX2: begin
                    r_var   <= var_full[VAR_W-1:0];
                    r_state <= B_SQRT;
                end
                B_SQRT: begin
                    if (!r_launch) begin
                        r_launch <= 1'b1;
                    end else if (sq_done) begin
                        r_launch <= 1'b0;
                        if (r_dev_dist) begin
                            r_st_ddev <= sq_root[DWD-1:0];
                            r_state   <= B_OUT;
                        end else begin
                            r_st_ldev <= sq_root[LW-1:0];
                            r_state   <= B_DIV_DQ;
                        end
                    end
                end
                B_OUT: begin
                    if (out_load) begin
                        r_out_data <= {5'd0, swls_pkg::FILL_W'(r_held),
                                       r_st_ddev, r_st_dmean, r_st_dmax, r_st_dmin,
                                       r_st_ldev, r_st_lmean, r_st_lmax, r_st_lmin};
                        r_out_user <= (r_held >= CNT_W'(2));
                        r_state    <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_tvalid = r_out_v;
    assign o_tdata  = r_out_data;
    assign o_tuser  = r_out_user;

endmodule

@@ rtl/sliding_window_link_stats.sv @@
// Link statistics over a sliding window of the last WINDOW valid samples.
// Each input transfer carries a signal level, the sender's and this node's
// position, and in tuser the own-position valid flag. A valid sample adds a
// level and a Euclidean distance pair to the window (oldest dropped when
// full); with two or more pairs held, min, max, truncated mean and sample
// deviation of both are recomputed. Every input transfer gives exactly one
// output transfer. The front computes the distance and takes no new sample
// until it has pushed the last into a two-entry queue to the back, whose
// cost sets the rate: a skipped sample or a window under two pairs goes
// straight to the output, while a recompute takes two scans of the window
// memory through its single read port, four passes of the shared
// bit-serial divider and two passes of the shared root unit. The output
// register frees the back as soon as a result is taken. No clearing pass
// is needed after reset.
module sliding_window_link_stats #(
    parameter int WINDOW = 100
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // rss_level, peer_x, peer_y, peer_z, own_x, own_y, own_z
    input  logic [swls_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // own_position_valid
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // level_min, level_max, level_mean, level_deviation, dist_min, dist_max,
    // dist_mean, dist_deviation, fill_level, zero padding
    output logic [swls_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // stats_valid
    output logic                                m_axis_tuser
);

    swls_pkg::t_handoff push;
    swls_pkg::t_entry   head;
    logic               full;
    logic               empty;
    logic               pop;

    swls_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .o_push   (push),
        .i_full   (full)
    );

    swls_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    swls_back #(.WINDOW(WINDOW)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule

@@ rtl/swls_checker.sv @@
module swls_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [swls_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tuser
);

    // A stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Without valid stats the window holds at most one pair
    a_fill_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[170:164] <= 7'd1)
        else $error("stats_valid low with two or more pairs");

    // Level mean lies between level min and max
    a_lvl_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            $signed(m_axis_tdata[15:0]) <= $signed(m_axis_tdata[47:32]) &&
            $signed(m_axis_tdata[47:32]) <= $signed(m_axis_tdata[31:16]))
        else $error("level min, mean, max out of order");

    // Distance mean lies between distance min and max
    a_dst_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[88:64] <= m_axis_tdata[138:114] &&
            m_axis_tdata[138:114] <= m_axis_tdata[113:89])
        else $error("distance min, mean, max out of order");

endmodule

bind sliding_window_link_stats swls_checker u_swls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int WIN        = 100;
    localparam int N_RANDOM   = 1930;
    localparam int QUIET_FROM = 1700;
    localparam int MAX_CYCLES = 5000000;

    // One input item, fields as carried on the slave side
    typedef struct {
        logic signed [15:0] level;
        logic signed [23:0] px, py, pz;
        logic signed [23:0] ox, oy, oz;
        logic               pos_ok;
    } t_link_sample;

    // One output item, fields as carried on the master side
    typedef struct {
        logic [15:0] lmin, lmax, lmean, ldev;
        logic [24:0] dmin, dmax, dmean, ddev;
        logic [6:0]  fill;
        logic        ok;
    } t_link_stats;

    // Directed row: fixed = expected result typed in (zero stats)
    typedef struct {
        t_link_sample s;
        logic         fixed;
        logic [6:0]   fill;
    } t_stim_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [swls_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // rss_level, peer_x/y/z, own_x/y/z
    logic                             s_axis_tuser;   // own_position_valid
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [swls_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // level/dist min/max/mean/dev, fill
    logic                             m_axis_tuser;   // stats_valid

    sliding_window_link_stats #(.WINDOW(WIN)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow window state
    longint       lvl_win [WIN];
    longint       dist_win[WIN];
    int           oldest_idx;
    int           n_held;
    t_link_stats  last_stats;
    t_link_stats  stats_q[$];

    int     n_sent;
    int     n_checked;
    int     n_valid_sent;
    int     n_errors;
    longint cycles = 0;

    // Truncated integer square root
    function automatic logic [63:0] int_root(input logic [127:0] v);
        logic [63:0]  r;
        logic [127:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = {64'd0, r | (64'd1 << b)};
            if (t * t <= v) r = t[63:0];
        end
        return r;
    endfunction

    // Floor of the sample deviation from count, sum and sum of squares
    function automatic logic [63:0] sample_sd(input longint n, input logic signed [127:0] s,
                                              input logic signed [127:0] sq);
        logic signed [127:0] num;
        logic signed [127:0] den;
        num = n * sq - s * s;
        den = n * (n - 1);
        return int_root(num / den);
    endfunction

    // Window update and stats for one accepted sample
    function automatic t_link_stats window_stats(input t_link_sample s);
        longint dx, dy, dz, lsum, dsum, lmn, lmx, dmn, dmx;
        logic signed [127:0] lsq, dsq;
        int slot;
        dx = longint'(s.px) - longint'(s.ox);
        dy = longint'(s.py) - longint'(s.oy);
        dz = longint'(s.pz) - longint'(s.oz);
        if (s.pos_ok) begin
            if (n_held < WIN) begin
                slot = (oldest_idx + n_held) % WIN;
                n_held++;
            end else begin
                slot = oldest_idx;
                oldest_idx = (oldest_idx + 1) % WIN;
            end
            lvl_win[slot]  = longint'(s.level);
            dist_win[slot] = longint'(int_root(128'(dx * dx + dy * dy + dz * dz)) & 64'h1FFFFFF);
            if (n_held >= 2) begin
                lsum = 0; dsum = 0; lsq = 0; dsq = 0;
                lmn = lvl_win[0]; lmx = lvl_win[0]; dmn = dist_win[0]; dmx = dist_win[0];
                for (int i = 0; i < n_held; i++) begin
                    lsum += lvl_win[i];
                    dsum += dist_win[i];
                    lsq  += 128'(lvl_win[i] * lvl_win[i]);
                    dsq  += 128'(dist_win[i] * dist_win[i]);
                    if (lvl_win[i] < lmn)  lmn = lvl_win[i];
                    if (lvl_win[i] > lmx)  lmx = lvl_win[i];
                    if (dist_win[i] < dmn) dmn = dist_win[i];
                    if (dist_win[i] > dmx) dmx = dist_win[i];
                end
                last_stats.lmin  = lmn[15:0];
                last_stats.lmax  = lmx[15:0];
                last_stats.lmean = 16'(lsum / n_held);
                last_stats.ldev  = 16'(sample_sd(n_held, 128'(lsum), lsq));
                last_stats.dmin  = dmn[24:0];
                last_stats.dmax  = dmx[24:0];
                last_stats.dmean = 25'(dsum / n_held);
                last_stats.ddev  = 25'(sample_sd(n_held, 128'(dsum), dsq));
            end
        end
        last_stats.fill = 7'(n_held);
        last_stats.ok   = (n_held >= 2);
        return last_stats;
    endfunction

    task automatic report_mismatch(input string fld, input logic [63:0] got,
                                   input logic [63:0] exp_v);
        $display("mismatch result %0d %s: got %0h, expected %0h", n_checked, fld, got, exp_v);
        n_errors++;
    endtask

    // Drive one sample and hold it until the transfer completes
    task automatic send_sample(input t_link_sample s, input logic fixed, input logic [6:0] fill);
        t_link_stats e;
        s_axis_tdata  <= {s.oz, s.oy, s.ox, s.pz, s.py, s.px, s.level};
        s_axis_tuser  <= s.pos_ok;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        e = window_stats(s);
        if (fixed) begin
            e = '{default: '0};
            e.fill = fill;
        end
        stats_q.insert(stats_q.size(), e);
        n_sent++;
        if (s.pos_ok) n_valid_sent++;
        // idle burst between transfers
        if (n_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [23:0] rand_coord(input int mode);
        case (mode)
            0:       return 24'sh800000;
            1:       return 24'sh7FFFFF;
            2:       return 24'($urandom_range(0, 2000)) - 24'sd1000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_link_sample rand_sample();
        t_link_sample s;
        int m;
        m = $urandom_range(0, 9);
        case ($urandom_range(0, 7))
            0:       s.level = 16'sh8000;
            1:       s.level = 16'sh7FFF;
            2, 3:    s.level = 16'($urandom_range(0, 600)) - 16'sd19000;
            default: s.level = 16'($urandom);
        endcase
        // mostly nearby positions, sometimes extremes or full range
        m = (m < 5) ? 2 : (m < 6) ? $urandom_range(0, 1) : 3;
        s.px = rand_coord(m); s.py = rand_coord(m); s.pz = rand_coord(m);
        m = (m == 2) ? 2 : $urandom_range(0, 3);
        s.ox = rand_coord(m); s.oy = rand_coord(m); s.oz = rand_coord(m);
        s.pos_ok = ($urandom_range(0, 9) != 0);
        return s;
    endfunction

    // Directed table: reset state, extremes, skipped samples, wrap-free fill
    t_stim_row rows[] = '{
        '{'{16'sh0000, 24'sd5, 24'sd5, 24'sd5, 24'sd0, 24'sd0, 24'sd0, 1'b0}, 1'b1, 7'd0},
        '{'{16'sh8000, 24'sh800000, 24'sh800000, 24'sh800000,
            24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1}, 1'b1, 7'd1},
        '{'{16'sh7FFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}, 1'b1, 7'd1},
        '{'{16'sh7FFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b0, 7'd0},
        '{'{16'sh7FFF, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
            24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b1}, 1'b0, 7'd0},
        '{'{16'sh8000, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}, 1'b0, 7'd0},
        '{'{16'shFFFF, 24'sd3, 24'sd4, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b0, 7'd0},
        '{'{16'sh0001, 24'shFFFFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd1, 1'b1}, 1'b0, 7'd0},
        '{'{16'sh5555, 24'sh555555, 24'shAAAAAA, 24'sh555555,
            24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 1'b1}, 1'b0, 7'd0},
        '{'{16'shAAAA, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA,
            24'sh555555, 24'shAAAAAA, 24'sh555555, 1'b1}, 1'b0, 7'd0},
        '{'{16'sh0000, 24'sd100, 24'sd100, 24'sd100, 24'sd100, 24'sd100, 24'sd100, 1'b1},
            1'b0, 7'd0},
        '{'{16'sh0000, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b0, 7'd0},
        '{'{16'sh0000, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}, 1'b0, 7'd0},
        '{'{16'sh7FFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
            24'sh800000, 24'sh800000, 24'sh800000, 1'b1}, 1'b0, 7'd0},
        '{'{16'sh8000, 24'sd1, 24'sd1, 24'sd1, 24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b0, 7'd0},
        '{'{16'shFF00, 24'sd16, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b0, 7'd0},
        '{'{16'sh0100, 24'sd0, 24'sd16, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b0, 7'd0},
        '{'{16'sh8001, 24'sd0, 24'sd0, 24'sd16, 24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b0, 7'd0},
        '{'{16'sh7FFE, 24'sh7FFFFF, 24'sd0, 24'sd0, 24'sh800000, 24'sd0, 24'sd0, 1'b1},
            1'b0, 7'd0},
        '{'{16'sh1234, 24'sh123456, 24'shFEDCBA, 24'sh000001,
            24'shFEDCBA, 24'sh123456, 24'shFFFFFF, 1'b1}, 1'b0, 7'd0}
    };

    // Result checker
    always @(posedge i_clk) begin
        t_link_stats e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (stats_q.size() == 0) begin
                $display("unexpected result transfer %0d", n_checked);
                n_errors++;
            end else begin
                e = stats_q.pop_front();
                if (m_axis_tdata[15:0]    !== e.lmin)  report_mismatch("level_min", m_axis_tdata[15:0], e.lmin);
                if (m_axis_tdata[31:16]   !== e.lmax)  report_mismatch("level_max", m_axis_tdata[31:16], e.lmax);
                if (m_axis_tdata[47:32]   !== e.lmean) report_mismatch("level_mean", m_axis_tdata[47:32], e.lmean);
                if (m_axis_tdata[63:48]   !== e.ldev)  report_mismatch("level_dev", m_axis_tdata[63:48], e.ldev);
                if (m_axis_tdata[88:64]   !== e.dmin)  report_mismatch("dist_min", m_axis_tdata[88:64], e.dmin);
                if (m_axis_tdata[113:89]  !== e.dmax)  report_mismatch("dist_max", m_axis_tdata[113:89], e.dmax);
                if (m_axis_tdata[138:114] !== e.dmean) report_mismatch("dist_mean", m_axis_tdata[138:114], e.dmean);
                if (m_axis_tdata[163:139] !== e.ddev)  report_mismatch("dist_dev", m_axis_tdata[163:139], e.ddev);
                if (m_axis_tdata[170:164] !== e.fill)  report_mismatch("fill_level", m_axis_tdata[170:164], e.fill);
                if (m_axis_tuser          !== e.ok)    report_mismatch("stats_valid", m_axis_tuser, e.ok);
            end
            n_checked++;
        end
    end

    // Receiver stalls in bursts, none near the end
    always @(posedge i_clk) begin
        if (!i_rst_n || n_sent >= QUIET_FROM) begin
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, stats_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        n_sent = 0; n_checked = 0; n_valid_sent = 0; n_errors = 0;
        oldest_idx = 0; n_held = 0;
        last_stats = '{default: '0};
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_sample(rows[i].s, rows[i].fixed, rows[i].fill);
        for (int i = 0; i < N_RANDOM; i++) send_sample(rand_sample(), 1'b0, 7'd0);
        s_axis_tvalid <= 1'b0;

        while (stats_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("%0d samples sent (%0d with own position), %0d results checked",
                 n_sent, n_valid_sent, n_checked);
        $display("window filled and wrapped, %0d mismatches", n_errors);
        if (n_errors == 0 && stats_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
